// File: rtl/core/smpq_pkg.sv
// Shared types and constants for the sorted max priority queue.
// Used by smpq_cell, sorted_max_priority_queue_unit and the testbench; no dependencies.
package smpq_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int COUNT_W = 5;   // width of the reported entry count
  localparam int ERR_W   = 2;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 2'd0,
    ERR_POP_EMPTY = 2'd1,
    ERR_PUSH_FULL = 2'd2
  } err_code_t;

  // operation broadcast to every cell of the chain
  typedef struct packed {
    logic                     push;
    logic                     pop;
    logic signed [DATA_W-1:0] value;
  } smpq_cmd_t;

endpackage

// File: rtl/core/smpq_cell.sv
// One slot of the sorted register chain: holds a value, compares the pushed
// value against it and shifts with its neighbors. Depends on smpq_pkg.
module smpq_cell (
  input  logic                              clk,
  input  smpq_pkg::smpq_cmd_t               cmd,
  input  logic                              occupied,
  input  logic                              prev_take,
  input  logic signed [smpq_pkg::DATA_W-1:0] prev_value,
  input  logic signed [smpq_pkg::DATA_W-1:0] right_value,
  output logic                              take,
  output logic signed [smpq_pkg::DATA_W-1:0] value,
  output logic signed [smpq_pkg::DATA_W-1:0] value_next
);
  import smpq_pkg::*;

  // empty slots always accept; the chain is monotone, so exactly one cell
  // sees take without prev_take and that one stores the new value
  assign take = occupied ? (cmd.value >= value) : 1'b1;

  always_comb begin
    value_next = value;
    if (cmd.push && take) begin
      value_next = prev_take ? prev_value : cmd.value;
    end else if (cmd.pop) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// File: rtl/core/sorted_max_priority_queue_unit.sv
// Sorted max priority queue built from a chain of smpq_cell slots.
// The result is registered and appears in the cycle after the input transfer.
// Throughput: one push or pop per cycle while the result is taken; every cell compares in parallel.
// A held result stalls input only while the output side is not ready.
// Reset (rst, synchronous): queue empties, no result pending; slot data is
// not cleared. Depends on smpq_pkg and smpq_cell.
module sorted_max_priority_queue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] push_value
  input  logic        s_tuser,   // [0] func: 0 push, 1 pop
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // [31:0] popped_value, [63:32] largest_value,
                                 // [64] largest_valid, [69:65] entry_count,
                                 // [71:70] error_code
);
  import smpq_pkg::*;

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     accept;
  logic                     is_pop;
  logic                     full;
  logic                     empty;
  smpq_cmd_t                cmd;
  err_code_t                err;
  logic signed [DATA_W-1:0] popped;

  logic                     take       [DEPTH];
  logic signed [DATA_W-1:0] cell_value [DEPTH];
  logic signed [DATA_W-1:0] cell_next  [DEPTH];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_pop   = s_tuser;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  always_comb begin
    cmd.push   = accept && !is_pop && !full;
    cmd.pop    = accept && is_pop && !empty;
    cmd.value  = $signed(s_tdata);
    count_next = count;
    err        = ERR_OK;
    popped     = '0;
    if (accept) begin
      if (is_pop) begin
        if (empty) begin
          err = ERR_POP_EMPTY;
        end else begin
          popped     = cell_value[0];
          count_next = count - 1'b1;
        end
      end else begin
        if (full) begin
          err = ERR_PUSH_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     prev_take_i;
    logic signed [DATA_W-1:0] prev_value_i;
    logic signed [DATA_W-1:0] right_value_i;

    if (i == 0) begin : g_head
      assign prev_take_i  = 1'b0;
      assign prev_value_i = '0;
    end else begin : g_body
      assign prev_take_i  = take[i-1];
      assign prev_value_i = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value_i = '0;
    end else begin : g_mid
      assign right_value_i = cell_value[i+1];
    end

    smpq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (CNT_W'(i) < count),
      .prev_take  (prev_take_i),
      .prev_value (prev_value_i),
      .right_value(right_value_i),
      .take       (take[i]),
      .value      (cell_value[i]),
      .value_next (cell_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata[31:0]  <= popped;
      m_tdata[63:32] <= (count_next != '0) ? cell_next[0] : '0;
      m_tdata[64]    <= (count_next != '0);
      m_tdata[69:65] <= COUNT_W'(count_next);
      m_tdata[71:70] <= err;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> count == $past(count) + 1'b1)
    else $error("accepted push did not grow the queue");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> count == $past(count) - 1'b1)
    else $error("accepted pop did not shrink the queue");

  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[71:70] == ERR_POP_EMPTY |-> m_tdata[69:65] == '0 && !m_tdata[64])
    else $error("pop-on-empty reported with nonzero count");

  a_valid_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[64] == (m_tdata[69:65] != '0))
    else $error("largest_valid disagrees with entry count");

endmodule

// File: sim/tb.sv
// Testbench for sorted_max_priority_queue_unit: random and directed push/pop traffic
// with a shadow copy of the sorted queue that predicts every result transfer.
// Depends on smpq_pkg and the queue RTL.
module tb;
  import smpq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int MAX_REPORTS    = 40;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped;
    logic signed [DATA_W-1:0] largest;
    logic                     valid;
    logic [COUNT_W-1:0]       count;
    err_code_t                err;
  } pq_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;

  // shadow of the queue contents, largest first
  logic signed [DATA_W-1:0] shadow_slots [DEPTH];
  int                       shadow_count;
  pq_result_t               pending_results [$];
  pq_result_t               want;

  int mismatches;
  int idle_cycles;
  int rx_idle_left;
  bit tx_idling;
  bit rx_idling;
  bit long_hold_req;

  sorted_max_priority_queue_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic pq_result_t apply_queue_op(input logic pop_op,
                                                input logic signed [DATA_W-1:0] value);
    pq_result_t r;
    int         pos;
    int         i;
    r     = '0;
    r.err = ERR_OK;
    if (pop_op == OP_PUSH) begin
      if (shadow_count >= DEPTH) begin
        r.err = ERR_PUSH_FULL;
      end else begin
        // lowest slot whose value is <= the new one; new value goes ahead of equals
        pos = shadow_count;
        for (i = shadow_count - 1; i >= 0; i--)
          if (value >= shadow_slots[i]) pos = i;
        for (i = shadow_count; i > pos; i--)
          shadow_slots[i] = shadow_slots[i-1];
        shadow_slots[pos] = value;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.err = ERR_POP_EMPTY;
    end else begin
      r.popped = shadow_slots[0];
      for (i = 1; i < shadow_count; i++)
        shadow_slots[i-1] = shadow_slots[i];
      shadow_count--;
    end
    r.valid   = (shadow_count > 0);
    r.largest = r.valid ? shadow_slots[0] : '0;
    r.count   = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3:    return int'($urandom_range(0, 8)) - 4;  // clusters of equal values
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input logic pop_op, input logic signed [DATA_W-1:0] value);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= pop_op;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_queue_op(pop_op, value));
    gap = tx_idling ? pick_gap() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic check_field(input string field, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
    end
  endtask

  // receiver: random ready gaps, plus one long hold-off on request
  initial begin
    m_tready     = 1'b0;
    rx_idle_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_idle_left > 0) begin
        m_tready <= 1'b0;
        rx_idle_left--;
      end else begin
        m_tready <= 1'b1;
        if (rx_idling && $urandom_range(0, 2) == 0) rx_idle_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result transfer with nothing expected, tdata %h", $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("popped_value", want.popped, $signed(m_tdata[31:0]));
        check_field("largest_value", want.largest, $signed(m_tdata[63:32]));
        check_field("largest_valid", want.valid, m_tdata[64]);
        check_field("entry_count", want.count, m_tdata[69:65]);
        check_field("error_code", want.err, m_tdata[71:70]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sorted_max_priority_queue_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_directed();
    send_item(OP_POP, '0);          // pop on empty
    send_item(OP_POP, VAL_MAX);     // pop on empty, data ignored
    send_item(OP_PUSH, VAL_MAX);
    send_item(OP_PUSH, VAL_MIN);
    send_item(OP_PUSH, '0);
    send_item(OP_PUSH, -1);
    send_item(OP_PUSH, 1);
    send_item(OP_PUSH, '0);         // equal to a stored value
    send_item(OP_PUSH, VAL_MAX);    // equal at the head
    send_item(OP_PUSH, VAL_MIN);    // equal at the tail
    repeat (8) send_item(OP_POP, $urandom());
    send_item(OP_POP, '0);          // empty again
  endtask

  task automatic test_fill_drain();
    repeat (DEPTH) send_item(OP_PUSH, rand_value());
    send_item(OP_PUSH, VAL_MAX);    // full: dropped
    send_item(OP_PUSH, VAL_MIN);
    send_item(OP_POP, '0);
    send_item(OP_PUSH, '0);
    send_item(OP_PUSH, -1);         // full again
    repeat (DEPTH) send_item(OP_POP, $urandom());
    send_item(OP_POP, '0);
  endtask

  // receiver stalls long while the sender keeps offering back to back
  task automatic test_back_pressure();
    tx_idling     = 1'b0;
    long_hold_req = 1'b1;
    repeat (40) send_item(1'($urandom_range(0, 1)), rand_value());
    tx_idling = 1'b1;
  endtask

  task automatic test_no_idle();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    repeat (60) send_item(1'($urandom_range(0, 1)), rand_value());
    tx_idling = 1'b1;
    rx_idling = 1'b1;
  endtask

  // push-heavy and pop-heavy stretches so the queue swings between full and empty
  task automatic test_random(input int n_items);
    int k;
    int push_pct;
    push_pct = 50;
    for (k = 0; k < n_items; k++) begin
      if (k % 30 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 25;
          default: push_pct = 50;
        endcase
      end
      if (k % 50 == 0) begin
        tx_idling = ($urandom_range(0, 3) != 0);
        rx_idling = ($urandom_range(0, 3) != 0);
      end
      send_item($urandom_range(0, 99) >= push_pct, rand_value());
    end
    tx_idling = 1'b1;
    rx_idling = 1'b1;
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = 1'b0;
    shadow_count  = 0;
    mismatches    = 0;
    tx_idling     = 1'b1;
    rx_idling     = 1'b1;
    long_hold_req = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_fill_drain();
    test_back_pressure();
    test_no_idle();
    test_random(400);

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("sorted_max_priority_queue_unit regression: pass");
    else
      $display("sorted_max_priority_queue_unit regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/smpq_pkg.sv
rtl/core/smpq_cell.sv
rtl/core/sorted_max_priority_queue_unit.sv
sim/tb.sv
